>>> design/kmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_pkg: shared types and constants
// Word format, operation and status codes, and sequencer states used by the
// front queue and the search engine of the first-match finder.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int PATTERN_MAX_DEF   = 64;
  localparam int POSITION_BITS_DEF = 24;
  localparam int SYM_W             = 8;
  localparam int STATUS_W          = 2;
  localparam int MATCH_START_W     = 24;
  localparam int QUEUE_DEPTH       = 4;

  typedef enum logic {
    OP_PATTERN = 1'b0,
    OP_TEXT    = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND      = 2'd0,
    STATUS_NOT_FOUND  = 2'd1,
    STATUS_NO_PATTERN = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
    logic             last;
  } item_t;

endpackage

>>> design/kmp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_front: input classifier and word queue
// Tags each accepted word as a pattern load or a text byte and holds it in a
// short queue until the search engine takes it.
// ----------------------------------------------------------------------------
module kmp_front
  import kmp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_req_type,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_is_last,
  output logic             q_valid,
  output item_t            q_item,
  input  logic             q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;
  item_t            in_item;

  assign in_full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];
  assign do_push = in_push && !in_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    in_item.op   = in_req_type ? OP_TEXT : OP_PATTERN;
    in_item.sym  = in_symbol;
    in_item.last = in_is_last;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> design/kmp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_back: search engine
// Builds the failure table as pattern bytes arrive and walks text bytes
// against the pattern, one memory read per step, with a result register.
// ----------------------------------------------------------------------------
module kmp_back
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [STATUS_W-1:0]      out_status,
  output logic [MATCH_START_W-1:0] out_match_start
);

  localparam int IDX_W = $clog2(PATTERN_MAX);
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CW0   = (POSITION_BITS + 1 > LEN_W) ? POSITION_BITS + 1 : LEN_W;
  localparam int CW    = (CW0 > MATCH_START_W) ? CW0 : MATCH_START_W;

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [SYM_W-1:0]         sym_r, sym_nxt;
  logic                     last_r, last_nxt;
  logic                     text_r, text_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic                     ready_r, ready_nxt;
  logic [IDX_W-1:0]         bpl_r, bpl_nxt;
  logic [IDX_W-1:0]         j_r, j_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     fin_r, fin_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [MATCH_START_W-1:0] out_start_r, out_start_nxt;

  logic [SYM_W-1:0]         pat_mem [PATTERN_MAX];
  logic [IDX_W-1:0]         fail_mem [PATTERN_MAX];
  logic [SYM_W-1:0]         pat_rd_r;
  logic [IDX_W-1:0]         fail_rd_r;
  logic [IDX_W-1:0]         pat_raddr, fail_raddr, mem_waddr;
  logic [SYM_W-1:0]         mem_wsym;
  logic [IDX_W-1:0]         mem_wfail;
  logic                     mem_we;

  logic                     out_free;
  logic                     walk_start, walk_done;
  logic                     emit;
  status_t                  emit_status;
  logic [MATCH_START_W-1:0] emit_start;

  function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] a);
    prev_idx = (a == '0) ? '0 : a - 1'b1;
  endfunction

  assign out_free        = !out_valid_r || out_pop;
  assign out_empty       = !out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_start = out_start_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (walk_start) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (walk_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    logic [LEN_W-1:0] i_eff;
    logic [IDX_W-1:0] k_eff;
    logic [IDX_W-1:0] j_eff;
    logic             hit;
    logic [LEN_W-1:0] final_len;
    logic             found;
    logic             need_res;
    logic [CW-1:0]    p1;
    logic [CW-1:0]    lw;
    logic [CW-1:0]    st_full;

    idx_nxt     = idx_r;
    sym_nxt     = sym_r;
    last_nxt    = last_r;
    text_nxt    = text_r;
    len_nxt     = len_r;
    ready_nxt   = ready_r;
    bpl_nxt     = bpl_r;
    j_nxt       = j_r;
    pos_nxt     = pos_r;
    fin_nxt     = fin_r;
    q_pop       = 1'b0;
    pat_raddr   = idx_r;
    fail_raddr  = prev_idx(idx_r);
    mem_we      = 1'b0;
    mem_waddr   = len_r[IDX_W-1:0];
    mem_wsym    = sym_r;
    mem_wfail   = '0;
    emit        = 1'b0;
    emit_status = STATUS_NOT_FOUND;
    emit_start  = '0;
    walk_start  = 1'b0;
    walk_done   = 1'b0;

    i_eff     = ready_r ? '0 : len_r;
    k_eff     = ready_r ? '0 : bpl_r;
    j_eff     = (LEN_W'(j_r) >= len_r) ? '0 : j_r;
    hit       = (pat_rd_r == sym_r);
    final_len = hit ? LEN_W'(idx_r) + 1'b1 : '0;
    found     = (final_len == len_r);
    need_res  = found || last_r;
    p1        = CW'(pos_r) + CW'(1);
    lw        = CW'(len_r);
    st_full   = (p1 >= lw) ? p1 - lw : '0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.op == OP_PATTERN) begin
            q_pop     = 1'b1;
            j_nxt     = '0;
            pos_nxt   = '0;
            fin_nxt   = 1'b0;
            ready_nxt = 1'b0;
            len_nxt   = i_eff;
            bpl_nxt   = k_eff;
            sym_nxt   = q_item.sym;
            last_nxt  = q_item.last;
            text_nxt  = 1'b0;
            if (i_eff == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wsym  = q_item.sym;
              mem_wfail = '0;
              bpl_nxt   = '0;
              len_nxt   = LEN_W'(1);
              ready_nxt = q_item.last;
            end else if (i_eff < LEN_W'(PATTERN_MAX)) begin
              idx_nxt    = k_eff;
              pat_raddr  = k_eff;
              fail_raddr = prev_idx(k_eff);
              walk_start = 1'b1;
            end else begin
              // drop bytes past the pattern capacity
              ready_nxt = q_item.last;
            end
          end else if (!ready_r) begin
            if (!q_item.last) begin
              q_pop = 1'b1;
            end else if (out_free) begin
              q_pop       = 1'b1;
              emit        = 1'b1;
              emit_status = STATUS_NO_PATTERN;
              j_nxt       = '0;
              pos_nxt     = '0;
              fin_nxt     = 1'b0;
            end
          end else if (fin_r) begin
            q_pop = 1'b1;
            if (q_item.last) begin
              j_nxt   = '0;
              pos_nxt = '0;
              fin_nxt = 1'b0;
            end
          end else begin
            q_pop      = 1'b1;
            idx_nxt    = j_eff;
            pat_raddr  = j_eff;
            fail_raddr = prev_idx(j_eff);
            sym_nxt    = q_item.sym;
            last_nxt   = q_item.last;
            text_nxt   = 1'b1;
            walk_start = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (!hit && idx_r != '0) begin
          // fall back along the failure chain
          idx_nxt    = fail_rd_r;
          pat_raddr  = fail_rd_r;
          fail_raddr = prev_idx(fail_rd_r);
        end else if (!text_r) begin
          mem_we    = 1'b1;
          mem_waddr = len_r[IDX_W-1:0];
          mem_wsym  = sym_r;
          mem_wfail = final_len[IDX_W-1:0];
          bpl_nxt   = final_len[IDX_W-1:0];
          len_nxt   = len_r + 1'b1;
          ready_nxt = last_r;
          walk_done = 1'b1;
        end else if (!need_res || out_free) begin
          walk_done   = 1'b1;
          emit        = need_res;
          emit_status = found ? STATUS_FOUND : STATUS_NOT_FOUND;
          emit_start  = found ? st_full[MATCH_START_W-1:0] : '0;
          j_nxt       = found ? '0 : final_len[IDX_W-1:0];
          fin_nxt     = found;
          pos_nxt     = (pos_r == {POSITION_BITS{1'b1}}) ? pos_r : pos_r + 1'b1;
          if (last_r) begin
            j_nxt   = '0;
            pos_nxt = '0;
            fin_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = emit_status;
      out_start_nxt  = emit_start;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      ready_r     <= 1'b0;
      bpl_r       <= '0;
      j_r         <= '0;
      pos_r       <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ready_r     <= ready_nxt;
      bpl_r       <= bpl_nxt;
      j_r         <= j_nxt;
      pos_r       <= pos_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    sym_r        <= sym_nxt;
    last_r       <= last_nxt;
    text_r       <= text_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pat_mem[mem_waddr]  <= mem_wsym;
      fail_mem[mem_waddr] <= mem_wfail;
    end
    pat_rd_r  <= pat_mem[pat_raddr];
    fail_rd_r <= fail_mem[fail_raddr];
  end

`ifndef ASSERT_OFF
  a_ready_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (len_r != '0))
    else $error("pattern marked ready with zero length");

  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> (LEN_W'(j_r) < len_r))
    else $error("matched count not below pattern length");

  a_fin_needs_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |-> ready_r)
    else $error("search finished without a loaded pattern");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK && text_r) |-> (LEN_W'(idx_r) < len_r))
    else $error("text walk index past pattern end");

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> (out_valid_r && $stable(out_start_r)))
    else $error("waiting result overwritten");
`endif

endmodule

>>> design/kmp_first_match_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_first_match_finder: streaming first-match string search
// Knuth-Morris-Pratt search of a byte text for a byte pattern loaded online.
// ----------------------------------------------------------------------------
// Words enter a four-deep queue and are taken one at a time by the search
// engine. A pattern byte that opens a pattern or lies past the capacity, a
// text byte after a match and a text byte with no pattern loaded are taken
// in the idle state alone; other pattern bytes and text bytes being searched
// also go through the walk state, with one more step per failure-table
// fallback, since each step is one read of the pattern and failure memories.
// Fallbacks average under one per byte over a stream, but a single byte can
// take up to its current prefix length in extra steps. The pattern memories
// need no clearing after reset; the block is ready at once. A result waits
// in an output register while the engine goes on with the next word.
module kmp_first_match_finder
  import kmp_pkg::*;
#(
  parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic                     in_req_type,
  input  logic [SYM_W-1:0]         in_symbol,
  input  logic                     in_is_last,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [STATUS_W-1:0]      out_status,
  output logic [MATCH_START_W-1:0] out_match_start
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  kmp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_req_type (in_req_type),
    .in_symbol   (in_symbol),
    .in_is_last  (in_is_last),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  kmp_back #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_match_start (out_match_start)
  );

endmodule

>>> verif/kmp_first_match_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_first_match_finder_test: self-checking bench for the first-match finder
// Loads byte patterns and streams byte texts through the push/full queue port.
// Every accepted word runs through a Knuth-Morris-Pratt model of the finder,
// and each popped result is compared against the oldest predicted verdict.
// Directed words cover the corner cases. Random rounds then mix well-formed
// pattern/text pairs with noise. Both sides idle at random, and one long
// output stall makes the block back up.
// ----------------------------------------------------------------------------
module kmp_first_match_finder_test;
  import kmp_pkg::*;

  localparam int PMAX  = PATTERN_MAX_DEF;
  localparam int LIMIT = 1500000;
  localparam int TAIL  = 400;
  localparam logic [POSITION_BITS_DEF-1:0] POS_TOP = {POSITION_BITS_DEF{1'b1}};

  typedef struct {
    op_t              op;
    logic [SYM_W-1:0] sym;
    logic             last;
    bit               drain;
  } word_t;

  typedef struct {
    status_t                  status;
    logic [MATCH_START_W-1:0] start;
  } verdict_t;

  typedef logic [SYM_W-1:0] byte_q_t[$];

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic                     in_req_type = 1'b0;
  logic [SYM_W-1:0]         in_symbol = '0;
  logic                     in_is_last = 1'b0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic [MATCH_START_W-1:0] out_match_start;

  kmp_first_match_finder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_req_type    (in_req_type),
    .in_symbol      (in_symbol),
    .in_is_last     (in_is_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_status     (out_status),
    .out_match_start(out_match_start)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // search model state
  logic [SYM_W-1:0]             pat_mem [PMAX];
  logic [5:0]                   fail_len[PMAX];
  int                           pat_len = 0;
  bit                           pat_ready = 0;
  int                           build_k = 0;
  int                           match_len = 0;
  logic [POSITION_BITS_DEF-1:0] text_pos = '0;
  bit                           search_done = 0;

  word_t    pending[$];
  verdict_t verdict_q[$];

  int cycle_cnt = 0;
  int err_cnt = 0;
  int sent_cnt = 0;
  int burst_mark = 0;
  int push_gap = 0;
  int pop_gap = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int found_cnt = 0;
  int miss_cnt = 0;
  int nopat_cnt = 0;

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cycle_cnt / 400) % 5 == 2) pick_gap = 0;
    else if (r < 55) pick_gap = 0;
    else if (r < 85) pick_gap = $urandom_range(1, 3);
    else if (r < 97) pick_gap = $urandom_range(4, 12);
    else pick_gap = $urandom_range(20, 60);
  endfunction

  function automatic void clear_search();
    match_len   = 0;
    text_pos    = '0;
    search_done = 0;
  endfunction

  function automatic void kmp_predict_word(op_t op, logic [SYM_W-1:0] sym, logic last);
    int     i;
    int     k;
    int     j;
    longint p;
    bit     hit;
    hit = 0;
    if (op == OP_PATTERN) begin
      if (pat_ready) begin
        pat_ready = 0;
        pat_len   = 0;
        build_k   = 0;
      end
      clear_search();
      i = pat_len;
      if (i < PMAX) begin
        pat_mem[i] = sym;
        k = 0;
        if (i != 0) begin
          k = build_k;
          while (k > 0 && pat_mem[k] != sym) k = fail_len[k-1];
          if (pat_mem[k] == sym) k++;
        end
        fail_len[i] = 6'(k);
        build_k     = k;
        pat_len     = i + 1;
      end
      if (last) pat_ready = 1;
    end else if (!pat_ready || pat_len == 0) begin
      if (last) begin
        verdict_q.push_back('{STATUS_NO_PATTERN, '0});
        clear_search();
      end
    end else begin
      if (!search_done) begin
        j = match_len;
        if (j >= pat_len) j = 0;
        while (j > 0 && pat_mem[j] != sym) j = fail_len[j-1];
        if (pat_mem[j] == sym) j++;
        if (j == pat_len) begin
          p = longint'(text_pos) + 1;
          p = (p >= pat_len) ? p - pat_len : 0;
          verdict_q.push_back('{STATUS_FOUND, MATCH_START_W'(p)});
          search_done = 1;
          j = 0;
          hit = 1;
        end
        match_len = j;
        if (text_pos != POS_TOP) text_pos = text_pos + 1'b1;
        if (last && !hit) verdict_q.push_back('{STATUS_NOT_FOUND, '0});
      end
      if (last) clear_search();
    end
  endfunction

  // driver: offer queued words, hold while full
  always @(posedge clk) begin : drive
    word_t w;
    if (!rst_n) begin
      in_push     <= 1'b0;
      in_req_type <= OP_PATTERN;
      in_symbol   <= '0;
      in_is_last  <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        kmp_predict_word(op_t'(in_req_type), in_symbol, in_is_last);
        sent_cnt++;
        push_gap = pick_gap();
      end
      if (!(in_push && in_full)) begin
        if (push_gap > 0) begin
          push_gap--;
          in_push <= 1'b0;
        end else if (pending.size() != 0 && !(pending[0].drain && verdict_q.size() != 0)) begin
          w = pending.pop_front();
          in_push     <= 1'b1;
          in_req_type <= w.op;
          in_symbol   <= w.sym;
          in_is_last  <= w.last;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor: pop results and check against the oldest verdict
  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: status %0d match_start %0d", out_status, out_match_start);
          err_cnt++;
        end else begin
          want = verdict_q.pop_front();
          case (want.status)
            STATUS_FOUND:     found_cnt++;
            STATUS_NOT_FOUND: miss_cnt++;
            default:          nopat_cnt++;
          endcase
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            err_cnt++;
          end
          if (out_match_start !== want.start) begin
            $error("match_start: expected %0d, got %0d", want.start, out_match_start);
            err_cnt++;
          end
        end
      end
      if (!hold_done && burst_mark > 0 && sent_cnt >= burst_mark) begin
        hold_left = 600;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        pop_gap = pick_gap();
      end
    end
  end

  task automatic add_word(op_t op, logic [SYM_W-1:0] sym, logic last, bit drain);
    pending.push_back('{op, sym, last, drain});
  endtask

  task automatic add_seq(op_t op, byte_q_t s, bit drain);
    foreach (s[n]) add_word(op, s[n], n == s.size() - 1, drain && n == 0);
  endtask

  initial begin : run_ctl
    byte_q_t pat;
    byte_q_t txt;
    int      base;
    int      span;
    int      plen;
    int      tlen;
    int      at;
    int      emb;
    int      r;
    int      round;
    bit      drain;

    // no pattern loaded yet
    add_word(OP_TEXT, 8'h41, 1'b1, 0);
    add_word(OP_TEXT, 8'h00, 1'b0, 0);
    add_word(OP_TEXT, 8'hFF, 1'b0, 0);
    add_word(OP_TEXT, 8'h5A, 1'b1, 0);
    // found mid-text, then found at 0 with trailing bytes ignored, then a miss
    add_word(OP_PATTERN, 8'h61, 1'b0, 0);
    add_word(OP_PATTERN, 8'h62, 1'b1, 0);
    add_word(OP_TEXT, 8'h78, 1'b0, 0);
    add_word(OP_TEXT, 8'h61, 1'b0, 0);
    add_word(OP_TEXT, 8'h62, 1'b1, 0);
    add_word(OP_TEXT, 8'h61, 1'b0, 0);
    add_word(OP_TEXT, 8'h62, 1'b0, 0);
    add_word(OP_TEXT, 8'h61, 1'b0, 0);
    add_word(OP_TEXT, 8'h63, 1'b1, 0);
    add_word(OP_TEXT, 8'h7A, 1'b0, 0);
    add_word(OP_TEXT, 8'h7A, 1'b1, 0);
    // pattern in progress counts as no pattern
    add_word(OP_PATTERN, 8'hFF, 1'b0, 0);
    add_word(OP_TEXT, 8'hFF, 1'b1, 0);
    add_word(OP_PATTERN, 8'h00, 1'b1, 0);
    add_word(OP_TEXT, 8'hFF, 1'b0, 0);
    add_word(OP_TEXT, 8'h00, 1'b1, 0);
    // pattern word interrupts a text in progress
    add_word(OP_TEXT, 8'hFF, 1'b0, 0);
    add_word(OP_PATTERN, 8'h61, 1'b1, 0);
    add_word(OP_TEXT, 8'h62, 1'b0, 0);
    add_word(OP_TEXT, 8'h61, 1'b1, 0);

    round = 0;
    while (pending.size() < 1650) begin
      drain = (round == 25) || ($urandom_range(0, 99) < 3);
      r = $urandom_range(0, 99);
      if (round == 12) begin
        burst_mark = pending.size();
        repeat (40) add_word(OP_TEXT, 8'(base + $urandom_range(0, span - 1)), 1'b1, 0);
      end else if (r < 80) begin
        if (round == 0 || $urandom_range(0, 2) == 0) begin
          base = $urandom_range(0, 255);
          span = $urandom_range(1, 4);
          r = $urandom_range(0, 99);
          if (round == 0 || r < 5) plen = $urandom_range(60, 70);
          else if (r < 15) plen = $urandom_range(9, 40);
          else plen = $urandom_range(1, 8);
          pat.delete();
          repeat (plen) pat.push_back(8'(base + $urandom_range(0, span - 1)));
          add_seq(OP_PATTERN, pat, drain);
          drain = 0;
        end
        tlen = $urandom_range(1, 24);
        txt.delete();
        repeat (tlen) txt.push_back(8'(base + $urandom_range(0, span - 1)));
        if ($urandom_range(0, 99) < 60) begin
          emb = (pat.size() > PMAX) ? PMAX : pat.size();
          at = $urandom_range(0, tlen);
          for (int m = 0; m < emb; m++) txt.insert(at + m, pat[m]);
        end
        add_seq(OP_TEXT, txt, drain);
      end else begin
        repeat ($urandom_range(1, 6))
          add_word(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   $urandom_range(0, 3) == 0, drain);
      end
      round++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while ((pending.size() != 0 || in_push || verdict_q.size() != 0) && cycle_cnt < LIMIT)
      @(posedge clk);
    if (cycle_cnt >= LIMIT) begin
      $display("kmp_first_match_finder_test: errors");
    end else begin
      repeat (TAIL) @(posedge clk);
      if (verdict_q.size() != 0) begin
        $error("%0d expected results never arrived", verdict_q.size());
        err_cnt++;
      end
      $display("%0d words sent in %0d rounds; results: %0d found, %0d not found, %0d no pattern",
               sent_cnt, round, found_cnt, miss_cnt, nopat_cnt);
      if (err_cnt == 0) begin
        $display("kmp_first_match_finder_test: clean");
      end else begin
        $display("kmp_first_match_finder_test: errors");
      end
    end
    $finish;
  end

endmodule

>>> kmp_first_match_finder.f
design/kmp_pkg.sv
design/kmp_front.sv
design/kmp_back.sv
design/kmp_first_match_finder.sv
verif/kmp_first_match_finder_test.sv
